@@ design/expr_tok_pkg.sv @@
// shared types and constants of the expression tokenizer
`timescale 1ns / 1ps
`default_nettype none

package expr_tok_pkg;

  // width of the saturating character counter
  localparam int unsigned PositionBits = 16;

  // characters with a special role
  localparam logic [7:0] ChSpace      = 8'h20;
  localparam logic [7:0] ChBackslash  = 8'h5c;
  localparam logic [7:0] ChQuote      = 8'h22;
  localparam logic [7:0] ChDot        = 8'h2e;
  localparam logic [7:0] ChUnderscore = 8'h5f;
  localparam logic [7:0] ChEquals     = 8'h3d;
  localparam logic [7:0] ChBang       = 8'h21;
  localparam logic [7:0] ChGreater    = 8'h3e;
  localparam logic [7:0] ChLess       = 8'h3c;

  typedef enum logic [4:0] {
    KindIdent   = 5'd0,
    KindNumber  = 5'd1,
    KindString  = 5'd2,
    KindAnd     = 5'd3,
    KindComma   = 5'd4,
    KindDiff    = 5'd5,
    KindSlash   = 5'd6,
    KindEq      = 5'd7,
    KindGe      = 5'd8,
    KindGt      = 5'd9,
    KindLe      = 5'd10,
    KindLt      = 5'd11,
    KindMinus   = 5'd12,
    KindPercent = 5'd13,
    KindStar    = 5'd14,
    KindColon   = 5'd15,
    KindNot     = 5'd16,
    KindLparen  = 5'd17,
    KindRparen  = 5'd18,
    KindBar     = 5'd19,
    KindPlus    = 5'd20,
    KindUnknown = 5'd21,
    KindEnd     = 5'd22,
    KindUnterm  = 5'd23
  } token_kind_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [7:0]  text_char;
    logic        text_valid;
    logic        token_last;
    logic [15:0] position;
  } out_item_t;

  // results produced by one item, first is delivered before second
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  first;
    out_item_t  second;
  } push_t;

endpackage

`default_nettype wire

@@ design/expr_tok_core.sv @@
// scan state machine and per-byte token decode
`timescale 1ns / 1ps
`default_nettype none

module expr_tok_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  expr_tok_pkg::in_item_t item_i,
  output expr_tok_pkg::push_t   push_o
);

  typedef enum logic [10:0] {
    ModeIdle      = 11'b000_0000_0001,
    ModeIdent     = 11'b000_0000_0010,
    ModeIdentEsc  = 11'b000_0000_0100,
    ModeNumber    = 11'b000_0000_1000,
    ModeString    = 11'b000_0001_0000,
    ModeStringEsc = 11'b000_0010_0000,
    ModeBang      = 11'b000_0100_0000,
    ModeGt        = 11'b000_1000_0000,
    ModeLt        = 11'b001_0000_0000,
    ModeDone      = 11'b010_0000_0000,
    ModeHalt      = 11'b100_0000_0000
  } mode_e;

  localparam int unsigned PB = expr_tok_pkg::PositionBits;

  mode_e                   mode_q, mode_d;
  logic [PB-1:0]           count_q, count_d, count_inc;
  logic [15:0]             pos;
  logic [7:0]              ch;
  logic                    is_alpha, is_digit, is_eq;
  mode_e                   st_mode;
  logic                    st_emit, st_text;
  expr_tok_pkg::token_kind_e st_kind;
  expr_tok_pkg::out_item_t st_res;
  expr_tok_pkg::token_kind_e pend_kind;

  function automatic expr_tok_pkg::out_item_t mk(input logic [4:0] kind, input logic [7:0] c,
                                                 input logic tv, input logic tl,
                                                 input logic [15:0] p);
    expr_tok_pkg::out_item_t r;
    r.token_kind = kind;
    r.text_char  = tv ? c : 8'h00;
    r.text_valid = tv;
    r.token_last = tl;
    r.position   = p;
    return r;
  endfunction

  assign ch        = item_i.ch;
  assign is_alpha  = (ch inside {[8'h41:8'h5a], [8'h61:8'h7a]});
  assign is_digit  = (ch inside {[8'h30:8'h39]});
  assign is_eq     = (ch == expr_tok_pkg::ChEquals);
  assign count_inc = (count_q != {PB{1'b1}}) ? count_q + 1'b1 : count_q;
  assign pos       = item_i.end_of_input ? 16'(count_q) : 16'(count_inc);

  // what the byte does when it opens a new token
  always_comb begin
    st_mode = ModeIdle;
    st_emit = 1'b0;
    st_text = 1'b0;
    st_kind = expr_tok_pkg::KindIdent;
    if (ch <= expr_tok_pkg::ChSpace || ch[7]) begin
      st_mode = ModeIdle;
    end else if (ch == expr_tok_pkg::ChBackslash) begin
      st_mode = ModeIdentEsc;
    end else if (is_alpha || ch == expr_tok_pkg::ChUnderscore) begin
      st_mode = ModeIdent;
      st_emit = 1'b1;
      st_text = 1'b1;
      st_kind = expr_tok_pkg::KindIdent;
    end else if (is_digit || ch == expr_tok_pkg::ChDot) begin
      st_mode = ModeNumber;
      st_emit = 1'b1;
      st_text = 1'b1;
      st_kind = expr_tok_pkg::KindNumber;
    end else if (ch == expr_tok_pkg::ChQuote) begin
      st_mode = ModeString;
    end else if (ch == expr_tok_pkg::ChBang) begin
      st_mode = ModeBang;
    end else if (ch == expr_tok_pkg::ChGreater) begin
      st_mode = ModeGt;
    end else if (ch == expr_tok_pkg::ChLess) begin
      st_mode = ModeLt;
    end else begin
      st_emit = 1'b1;
      case (ch)
        "&":     st_kind = expr_tok_pkg::KindAnd;
        ",":     st_kind = expr_tok_pkg::KindComma;
        "/":     st_kind = expr_tok_pkg::KindSlash;
        "=":     st_kind = expr_tok_pkg::KindEq;
        "-":     st_kind = expr_tok_pkg::KindMinus;
        "%":     st_kind = expr_tok_pkg::KindPercent;
        "*":     st_kind = expr_tok_pkg::KindStar;
        ":":     st_kind = expr_tok_pkg::KindColon;
        "(":     st_kind = expr_tok_pkg::KindLparen;
        ")":     st_kind = expr_tok_pkg::KindRparen;
        "|":     st_kind = expr_tok_pkg::KindBar;
        "+":     st_kind = expr_tok_pkg::KindPlus;
        default: begin
          st_kind = expr_tok_pkg::KindUnknown;
          st_mode = ModeHalt;
        end
      endcase
    end
  end

  assign st_res = mk(st_kind, ch, st_text, !st_text, pos);

  // kind of a pending comparison or negation operator
  always_comb begin
    case (mode_q)
      ModeBang: pend_kind = is_eq ? expr_tok_pkg::KindDiff : expr_tok_pkg::KindNot;
      ModeGt:   pend_kind = is_eq ? expr_tok_pkg::KindGe : expr_tok_pkg::KindGt;
      ModeLt:   pend_kind = is_eq ? expr_tok_pkg::KindLe : expr_tok_pkg::KindLt;
      default:  pend_kind = expr_tok_pkg::KindNot;
    endcase
  end

  always_comb begin
    mode_d        = mode_q;
    count_d       = count_q;
    push_o.cnt    = 2'd0;
    push_o.first  = st_res;
    push_o.second = st_res;
    if (fire_i && mode_q != ModeDone && mode_q != ModeHalt) begin
      if (item_i.end_of_input) begin
        push_o.second = mk(expr_tok_pkg::KindEnd, 8'h00, 1'b0, 1'b1, pos);
        mode_d        = ModeDone;
        push_o.cnt    = 2'd2;
        case (mode_q)
          ModeIdent:  push_o.first = mk(expr_tok_pkg::KindIdent, 8'h00, 1'b0, 1'b1, pos);
          ModeNumber: push_o.first = mk(expr_tok_pkg::KindNumber, 8'h00, 1'b0, 1'b1, pos);
          ModeBang:   push_o.first = mk(expr_tok_pkg::KindNot, 8'h00, 1'b0, 1'b1, pos);
          ModeGt:     push_o.first = mk(expr_tok_pkg::KindGt, 8'h00, 1'b0, 1'b1, pos);
          ModeLt:     push_o.first = mk(expr_tok_pkg::KindLt, 8'h00, 1'b0, 1'b1, pos);
          ModeIdentEsc, ModeString, ModeStringEsc: begin
            push_o.first = mk(expr_tok_pkg::KindUnterm, 8'h00, 1'b0, 1'b1, pos);
            push_o.cnt   = 2'd1;
            mode_d       = ModeHalt;
          end
          default: begin
            push_o.first = mk(expr_tok_pkg::KindEnd, 8'h00, 1'b0, 1'b1, pos);
            push_o.cnt   = 2'd1;
          end
        endcase
      end else begin
        count_d = count_inc;
        case (mode_q)
          ModeIdent: begin
            if (ch == expr_tok_pkg::ChBackslash) begin
              mode_d = ModeIdentEsc;
            end else if (is_alpha || is_digit || ch == expr_tok_pkg::ChDot ||
                         ch == expr_tok_pkg::ChUnderscore) begin
              push_o.first = mk(expr_tok_pkg::KindIdent, ch, 1'b1, 1'b0, pos);
              push_o.cnt   = 2'd1;
            end else begin
              // close the identifier, then the byte opens the next token
              push_o.first = mk(expr_tok_pkg::KindIdent, 8'h00, 1'b0, 1'b1, pos);
              push_o.cnt   = st_emit ? 2'd2 : 2'd1;
              mode_d       = st_mode;
            end
          end
          ModeIdentEsc: begin
            push_o.first = mk(expr_tok_pkg::KindIdent, ch, 1'b1, 1'b0, pos);
            push_o.cnt   = 2'd1;
            mode_d       = ModeIdent;
          end
          ModeNumber: begin
            if (is_digit || ch == expr_tok_pkg::ChDot) begin
              push_o.first = mk(expr_tok_pkg::KindNumber, ch, 1'b1, 1'b0, pos);
              push_o.cnt   = 2'd1;
            end else begin
              push_o.first = mk(expr_tok_pkg::KindNumber, 8'h00, 1'b0, 1'b1, pos);
              push_o.cnt   = st_emit ? 2'd2 : 2'd1;
              mode_d       = st_mode;
            end
          end
          ModeString: begin
            if (ch == expr_tok_pkg::ChQuote) begin
              push_o.first = mk(expr_tok_pkg::KindString, 8'h00, 1'b0, 1'b1, pos);
              push_o.cnt   = 2'd1;
              mode_d       = ModeIdle;
            end else if (ch == expr_tok_pkg::ChBackslash) begin
              mode_d = ModeStringEsc;
            end else begin
              push_o.first = mk(expr_tok_pkg::KindString, ch, 1'b1, 1'b0, pos);
              push_o.cnt   = 2'd1;
            end
          end
          ModeStringEsc: begin
            push_o.first = mk(expr_tok_pkg::KindString, ch, 1'b1, 1'b0, pos);
            push_o.cnt   = 2'd1;
            mode_d       = ModeString;
          end
          ModeBang, ModeGt, ModeLt: begin
            push_o.first = mk(pend_kind, 8'h00, 1'b0, 1'b1, pos);
            if (is_eq) begin
              push_o.cnt = 2'd1;
              mode_d     = ModeIdle;
            end else begin
              push_o.cnt = st_emit ? 2'd2 : 2'd1;
              mode_d     = st_mode;
            end
          end
          default: begin
            push_o.first = st_res;
            push_o.cnt   = st_emit ? 2'd1 : 2'd0;
            mode_d       = st_mode;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      count_q <= '0;
    end else begin
      mode_q  <= mode_d;
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

@@ design/expr_tok_fifo.sv @@
// four-entry result queue taking up to two results a cycle
`timescale 1ns / 1ps
`default_nettype none

module expr_tok_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  expr_tok_pkg::push_t     push_i,
  output logic                    room_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output expr_tok_pkg::out_item_t out_item_o
);

  expr_tok_pkg::out_item_t entry_q [4];
  logic [1:0] rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [2:0] count_q, count_d;
  logic       pop;

  assign out_valid_o = (count_q != 3'd0);
  assign out_item_o  = entry_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  // two free slots needed before an item may be decoded
  assign room_o      = (count_q <= 3'd2);

  assign rd_ptr_d = rd_ptr_q + {1'b0, pop};
  assign wr_ptr_d = wr_ptr_q + push_i.cnt;
  assign count_d  = count_q + {1'b0, push_i.cnt} - {2'b00, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      entry_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.cnt == 2'd2) begin
      entry_q[wr_ptr_q + 2'd1] <= push_i.second;
    end
  end

endmodule

`default_nettype wire

@@ design/expression_tokenizer.sv @@
// top level of the streaming expression tokenizer
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------
//   input   | in        | in_valid_i / in_stall_o   | in_item_i   (byte or end)
//   result  | out       | out_valid_o / out_stall_i | out_item_o  (text or token)
//
// an accepted byte waits in the input register until the queue has room, is
// decoded in one pass and is written into the result queue, which offers it
// on the result port
// one item can be taken every cycle while the queue has room; each yields zero
// to two results and an unstalled result port moves one per cycle, so the
// sustained rate is one item per cycle only when items give single results
// reset clears the scan mode, the position counter, the input valid flag and the
// queue pointers; no clearing pass is needed
// in_stall_o rises only when a decoded item would not fit in the queue (fewer
// than two free entries), so back-pressure on the result side reaches the input
// after the queue fills
`timescale 1ns / 1ps
`default_nettype none

module expression_tokenizer (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  expr_tok_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output expr_tok_pkg::out_item_t out_item_o
);

  // input register
  logic                   in_valid_q;
  expr_tok_pkg::in_item_t in_item_q;
  logic                   in_accept;
  // decode happens when the queue has space for the worst case burst
  logic                   room;
  logic                   fire;
  expr_tok_pkg::push_t    push;

  assign fire       = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q <= in_item_i;
    end
  end

  // scan mode, position and the results of one transaction
  expr_tok_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_item_q),
    .push_o (push)
  );

  // result queue, drives the output port straight from its entries
  expr_tok_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

@@ design/expr_tok_checker.sv @@
// port-level checks of the expression tokenizer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module expr_tok_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input expr_tok_pkg::out_item_t out_item_o
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // a stalled result keeps its contents
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("result changed while stalled");

  // a closing result carries no text and a text result never closes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.text_valid && out_item_o.token_last) &&
                    (out_item_o.text_valid || out_item_o.token_last))
    else $error("result neither text nor closing, or both");

  // text belongs to identifiers, numbers or strings only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.text_valid |->
      out_item_o.token_kind <= expr_tok_pkg::KindString)
    else $error("text on an operator or status result");

  // a non-text result has a cleared character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.text_valid |-> out_item_o.text_char == 8'h00)
    else $error("character set on a closing result");

endmodule

bind expression_tokenizer expr_tok_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire

@@ dv/testbench.sv @@
// self-checking testbench of the expression tokenizer
`timescale 1ns / 1ps

module testbench;

  localparam int HoldOffCycles = 300;
  localparam int DrainCycles   = 40;

  localparam string IdentHead    = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  localparam string IdentBody    = "abcxyzABCXYZ0123456789._";
  localparam string NumberChars  = "0123456789.";
  localparam string OperatorChars = "&,/=-%*:()|+";

  // scan modes of the tokenizer, private to the testbench
  typedef enum logic [3:0] {
    ScanIdle, ScanIdent, ScanIdentEsc, ScanNumber, ScanString, ScanStringEsc,
    ScanBang, ScanGt, ScanLt, ScanDone, ScanHalt
  } scan_mode_e;

  typedef struct {
    logic [7:0]              ch;
    bit                      typed;
    expr_tok_pkg::out_item_t want;
  } directed_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  expr_tok_pkg::in_item_t  in_item = '0;
  logic                    out_stall = 1'b1;
  logic                    in_stall;
  logic                    out_valid;
  expr_tok_pkg::out_item_t out_item;

  // tokenizer image and the results it still owes
  scan_mode_e                            scan_state = ScanIdle;
  logic [expr_tok_pkg::PositionBits-1:0] char_pos = '0;
  expr_tok_pkg::out_item_t               token_stream [$];
  logic [7:0]                            lexeme_bytes [$];

  int error_count = 0;
  int text_items = 0;
  int burst_left = 0;
  bit hold_off_request = 1'b0;

  // short opening text; rows with a typed result give exactly one result
  directed_row_t directed_rows [25] = '{
    '{expr_tok_pkg::ChSpace,      1'b0, '0},
    '{8'h80,                      1'b0, '0},
    '{"+",                        1'b1, {expr_tok_pkg::KindPlus, 8'h00, 1'b0, 1'b1, 16'd3}},
    '{"a",                        1'b1, {expr_tok_pkg::KindIdent, "a", 1'b1, 1'b0, 16'd4}},
    '{expr_tok_pkg::ChBackslash,  1'b0, '0},
    '{8'hff,                      1'b1, {expr_tok_pkg::KindIdent, 8'hff, 1'b1, 1'b0, 16'd6}},
    '{"9",                        1'b0, '0},
    '{expr_tok_pkg::ChGreater,    1'b0, '0},
    '{expr_tok_pkg::ChEquals,     1'b1, {expr_tok_pkg::KindGe, 8'h00, 1'b0, 1'b1, 16'd9}},
    '{expr_tok_pkg::ChBang,       1'b0, '0},
    '{"x",                        1'b0, '0},
    '{expr_tok_pkg::ChLess,       1'b0, '0},
    '{expr_tok_pkg::ChLess,       1'b0, '0},
    '{"1",                        1'b0, '0},
    '{expr_tok_pkg::ChDot,        1'b0, '0},
    '{expr_tok_pkg::ChQuote,      1'b0, '0},
    '{expr_tok_pkg::ChBackslash,  1'b0, '0},
    '{expr_tok_pkg::ChQuote,      1'b0, '0},
    '{8'h00,                      1'b1, {expr_tok_pkg::KindString, 8'h00, 1'b1, 1'b0, 16'd19}},
    '{expr_tok_pkg::ChQuote,      1'b1, {expr_tok_pkg::KindString, 8'h00, 1'b0, 1'b1, 16'd20}},
    '{expr_tok_pkg::ChBang,       1'b0, '0},
    '{expr_tok_pkg::ChEquals,     1'b1, {expr_tok_pkg::KindDiff, 8'h00, 1'b0, 1'b1, 16'd22}},
    '{expr_tok_pkg::ChUnderscore, 1'b1,
      {expr_tok_pkg::KindIdent, expr_tok_pkg::ChUnderscore, 1'b1, 1'b0, 16'd23}},
    '{"&",                        1'b0, '0},
    '{8'h1f,                      1'b0, '0}
  };

  expression_tokenizer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit lookup_operator(input logic [7:0] c,
                                         output expr_tok_pkg::token_kind_e kind);
    kind = expr_tok_pkg::KindUnknown;
    case (c)
      "&":                   kind = expr_tok_pkg::KindAnd;
      ",":                   kind = expr_tok_pkg::KindComma;
      "/":                   kind = expr_tok_pkg::KindSlash;
      expr_tok_pkg::ChEquals: kind = expr_tok_pkg::KindEq;
      "-":                   kind = expr_tok_pkg::KindMinus;
      "%":                   kind = expr_tok_pkg::KindPercent;
      "*":                   kind = expr_tok_pkg::KindStar;
      ":":                   kind = expr_tok_pkg::KindColon;
      "(":                   kind = expr_tok_pkg::KindLparen;
      ")":                   kind = expr_tok_pkg::KindRparen;
      "|":                   kind = expr_tok_pkg::KindBar;
      "+":                   kind = expr_tok_pkg::KindPlus;
      default:               return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // printable byte that cannot start any token
  function automatic bit is_stray(logic [7:0] c);
    expr_tok_pkg::token_kind_e kind;
    if (c <= expr_tok_pkg::ChSpace || c[7] || is_letter(c) || is_digit(c)) return 1'b0;
    if (c == expr_tok_pkg::ChBackslash || c == expr_tok_pkg::ChUnderscore ||
        c == expr_tok_pkg::ChDot || c == expr_tok_pkg::ChQuote) return 1'b0;
    if (c == expr_tok_pkg::ChBang || c == expr_tok_pkg::ChGreater ||
        c == expr_tok_pkg::ChLess) return 1'b0;
    return !lookup_operator(c, kind);
  endfunction

  function automatic void emit(expr_tok_pkg::token_kind_e kind, logic [7:0] c, logic text,
                               logic last);
    expr_tok_pkg::out_item_t r;
    r.token_kind = kind;
    r.text_char  = text ? c : 8'h00;
    r.text_valid = text;
    r.token_last = last;
    r.position   = 16'(char_pos);
    token_stream.push_back(r);
  endfunction

  function automatic void start_token(logic [7:0] c);
    expr_tok_pkg::token_kind_e kind;
    if (c <= expr_tok_pkg::ChSpace || c[7]) begin
      scan_state = ScanIdle;
    end else if (c == expr_tok_pkg::ChBackslash) begin
      scan_state = ScanIdentEsc;
    end else if (is_letter(c) || c == expr_tok_pkg::ChUnderscore) begin
      scan_state = ScanIdent;
      emit(expr_tok_pkg::KindIdent, c, 1'b1, 1'b0);
    end else if (is_digit(c) || c == expr_tok_pkg::ChDot) begin
      scan_state = ScanNumber;
      emit(expr_tok_pkg::KindNumber, c, 1'b1, 1'b0);
    end else if (c == expr_tok_pkg::ChQuote) begin
      scan_state = ScanString;
    end else if (c == expr_tok_pkg::ChBang) begin
      scan_state = ScanBang;
    end else if (c == expr_tok_pkg::ChGreater) begin
      scan_state = ScanGt;
    end else if (c == expr_tok_pkg::ChLess) begin
      scan_state = ScanLt;
    end else if (lookup_operator(c, kind)) begin
      scan_state = ScanIdle;
      emit(kind, 8'h00, 1'b0, 1'b1);
    end else begin
      // unknown byte halts the tokenizer
      scan_state = ScanHalt;
      emit(expr_tok_pkg::KindUnknown, 8'h00, 1'b0, 1'b1);
    end
  endfunction

  // end of text: close the open token, then report the end; an open escape or string reports unterminated and halts
  function automatic void close_at_end();
    case (scan_state)
      ScanIdent:  emit(expr_tok_pkg::KindIdent, 8'h00, 1'b0, 1'b1);
      ScanNumber: emit(expr_tok_pkg::KindNumber, 8'h00, 1'b0, 1'b1);
      ScanBang:   emit(expr_tok_pkg::KindNot, 8'h00, 1'b0, 1'b1);
      ScanGt:     emit(expr_tok_pkg::KindGt, 8'h00, 1'b0, 1'b1);
      ScanLt:     emit(expr_tok_pkg::KindLt, 8'h00, 1'b0, 1'b1);
      ScanIdentEsc, ScanString, ScanStringEsc: begin
        emit(expr_tok_pkg::KindUnterm, 8'h00, 1'b0, 1'b1);
        scan_state = ScanHalt;
        return;
      end
      default: ;
    endcase
    emit(expr_tok_pkg::KindEnd, 8'h00, 1'b0, 1'b1);
    scan_state = ScanDone;
  endfunction

  function automatic void tokenize_item(expr_tok_pkg::in_item_t it);
    logic [7:0]                c;
    expr_tok_pkg::token_kind_e pair;
    c = it.ch;
    if (scan_state == ScanDone || scan_state == ScanHalt) return;
    if (it.end_of_input) begin
      close_at_end();
      return;
    end
    if (char_pos != '1) char_pos = char_pos + 1'b1;
    case (scan_state)
      ScanIdent: begin
        if (c == expr_tok_pkg::ChBackslash) begin
          scan_state = ScanIdentEsc;
        end else if (is_letter(c) || is_digit(c) || c == expr_tok_pkg::ChDot ||
                     c == expr_tok_pkg::ChUnderscore) begin
          emit(expr_tok_pkg::KindIdent, c, 1'b1, 1'b0);
        end else begin
          emit(expr_tok_pkg::KindIdent, 8'h00, 1'b0, 1'b1);
          start_token(c);
        end
      end
      ScanIdentEsc: begin
        scan_state = ScanIdent;
        emit(expr_tok_pkg::KindIdent, c, 1'b1, 1'b0);
      end
      ScanNumber: begin
        if (is_digit(c) || c == expr_tok_pkg::ChDot) begin
          emit(expr_tok_pkg::KindNumber, c, 1'b1, 1'b0);
        end else begin
          emit(expr_tok_pkg::KindNumber, 8'h00, 1'b0, 1'b1);
          start_token(c);
        end
      end
      ScanString: begin
        if (c == expr_tok_pkg::ChQuote) begin
          scan_state = ScanIdle;
          emit(expr_tok_pkg::KindString, 8'h00, 1'b0, 1'b1);
        end else if (c == expr_tok_pkg::ChBackslash) begin
          scan_state = ScanStringEsc;
        end else begin
          emit(expr_tok_pkg::KindString, c, 1'b1, 1'b0);
        end
      end
      ScanStringEsc: begin
        scan_state = ScanString;
        emit(expr_tok_pkg::KindString, c, 1'b1, 1'b0);
      end
      ScanBang, ScanGt, ScanLt: begin
        // pending operator: either pairs with '=' or stands alone
        if (scan_state == ScanBang) begin
          pair = (c == expr_tok_pkg::ChEquals) ? expr_tok_pkg::KindDiff
                                               : expr_tok_pkg::KindNot;
        end else if (scan_state == ScanGt) begin
          pair = (c == expr_tok_pkg::ChEquals) ? expr_tok_pkg::KindGe
                                               : expr_tok_pkg::KindGt;
        end else begin
          pair = (c == expr_tok_pkg::ChEquals) ? expr_tok_pkg::KindLe
                                               : expr_tok_pkg::KindLt;
        end
        emit(pair, 8'h00, 1'b0, 1'b1);
        if (c == expr_tok_pkg::ChEquals) scan_state = ScanIdle;
        else start_token(c);
      end
      default: start_token(c);
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string msg);
    if (error_count < 50) $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  always @(posedge clk) begin : result_check
    expr_tok_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (token_stream.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", out_item));
      end else begin
        want = token_stream.pop_front();
        if (out_item.token_kind !== want.token_kind)
          report_mismatch($sformatf("token_kind %0d, expected %0d at position %0d",
                                    out_item.token_kind, want.token_kind, want.position));
        if (out_item.text_char !== want.text_char)
          report_mismatch($sformatf("text_char %h, expected %h at position %0d",
                                    out_item.text_char, want.text_char, want.position));
        if (out_item.text_valid !== want.text_valid)
          report_mismatch($sformatf("text_valid %b, expected %b at position %0d",
                                    out_item.text_valid, want.text_valid, want.position));
        if (out_item.token_last !== want.token_last)
          report_mismatch($sformatf("token_last %b, expected %b at position %0d",
                                    out_item.token_last, want.token_last, want.position));
        if (out_item.position !== want.position)
          report_mismatch($sformatf("position %0d, expected %0d",
                                    out_item.position, want.position));
      end
    end
  end

  // ---------------------------------------------------------------- result side

  // own stall pattern; a raised hold-off request holds the port for a long stretch
  initial begin : result_stall_pattern
    int run;
    int mode;
    forever begin
      if (hold_off_request) begin
        out_stall <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk);
        hold_off_request = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        run  = (mode == 3) ? $urandom_range(1, 6) : $urandom_range(1, 32);
        repeat (run) begin
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= 1'($urandom_range(0, 1));
            2:       out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= 1'b1;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // ---------------------------------------------------------------- input side

  function automatic logic [7:0] pick_char(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  // byte that is skipped between tokens
  function automatic logic [7:0] skip_byte();
    logic [7:0] c;
    if ($urandom_range(0, 1)) c = 8'($urandom_range(0, 32));
    else c = 8'($urandom_range(128, 255));
    return c;
  endfunction

  // one transaction on the input port, predicted when it is taken
  task automatic offer_item(logic [7:0] c, logic eoi);
    expr_tok_pkg::in_item_t it;
    it.ch = c;
    it.end_of_input = eoi;
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    tokenize_item(it);
    text_items++;
  endtask

  // bursts of random length with random gaps between them
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(0, 16);
    gap = $urandom_range(1, 8);
    in_valid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  task automatic offer_paced(logic [7:0] c, logic eoi);
    offer_item(c, eoi);
    pace_sender();
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (token_stream.size() != 0) @(posedge clk);
  endtask

  // bytes of one well-formed token with random content, now and then broken
  function automatic void compose_token();
    int         len;
    int         i;
    logic [7:0] c;
    len = $urandom_range(1, 6);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        for (i = 0; i < len; i++) begin
          if ($urandom_range(0, 7) == 0) begin
            c = 8'($urandom_range(0, 255));
            lexeme_bytes.push_back(expr_tok_pkg::ChBackslash);
            lexeme_bytes.push_back(c);
          end else begin
            lexeme_bytes.push_back(pick_char(i == 0 ? IdentHead : IdentBody));
          end
        end
        if ($urandom_range(0, 3) != 0) lexeme_bytes.push_back(skip_byte());
      end
      3: begin
        for (i = 0; i < len; i++) lexeme_bytes.push_back(pick_char(NumberChars));
        if ($urandom_range(0, 3) != 0) lexeme_bytes.push_back(skip_byte());
      end
      4: begin
        lexeme_bytes.push_back(expr_tok_pkg::ChQuote);
        for (i = 1; i < len; i++) begin
          c = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 4) == 0) begin
            lexeme_bytes.push_back(expr_tok_pkg::ChBackslash);
          end else begin
            while (c == expr_tok_pkg::ChQuote || c == expr_tok_pkg::ChBackslash)
              c = 8'($urandom_range(0, 255));
          end
          lexeme_bytes.push_back(c);
        end
        // now and then the closing quote is missing
        if ($urandom_range(0, 15) != 0) lexeme_bytes.push_back(expr_tok_pkg::ChQuote);
      end
      5, 6: begin
        if ($urandom_range(0, 2) != 0) begin
          lexeme_bytes.push_back(pick_char(OperatorChars));
        end else begin
          lexeme_bytes.push_back(pick_char("!<>"));
          if ($urandom_range(0, 1)) lexeme_bytes.push_back(expr_tok_pkg::ChEquals);
        end
      end
      7, 8: begin
        for (i = 0; i < (len + 1) / 2; i++) lexeme_bytes.push_back(skip_byte());
      end
      default: begin
        do c = 8'($urandom_range(0, 255)); while (is_stray(c));
        lexeme_bytes.push_back(c);
      end
    endcase
  endfunction

  task automatic send_token();
    compose_token();
    while (lexeme_bytes.size() != 0) offer_paced(lexeme_bytes.pop_front(), 1'b0);
  endtask

  // the text ends in one of the ways the tokenizer can stop, chosen at random
  task automatic close_text();
    logic [7:0] c;
    int         i;
    case ($urandom_range(0, 4))
      0: offer_paced(skip_byte(), 1'b0);
      1: offer_paced(pick_char("!<>aZ_9."), 1'b0);
      2: begin
        do c = 8'($urandom_range(33, 127)); while (!is_stray(c));
        offer_paced(c, 1'b0);
      end
      3: begin
        offer_paced(expr_tok_pkg::ChQuote, 1'b0);
        offer_paced(pick_char(IdentBody), 1'b0);
      end
      default: begin
        if ($urandom_range(0, 1)) offer_paced(expr_tok_pkg::ChQuote, 1'b0);
        offer_paced(expr_tok_pkg::ChBackslash, 1'b0);
      end
    endcase
    c = 8'($urandom_range(0, 255));
    offer_paced(c, 1'b1);
    // stopped for good: these must give no result
    for (i = 0; i < 6; i++) begin
      c = 8'($urandom_range(0, 255));
      offer_paced(c, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin : stimulus
    int target;
    int i;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < 25; i++) begin
      offer_item(directed_rows[i].ch, 1'b0);
      if (directed_rows[i].typed) begin
        token_stream.delete(token_stream.size() - 1);
        token_stream.push_back(directed_rows[i].want);
      end
      pace_sender();
    end

    // pause until the opening text has fully come out
    drain_results();

    while (text_items < 250) send_token();

    // long hold-off on the result side while operators keep coming
    hold_off_request = 1'b1;
    repeat (60) offer_item(pick_char(OperatorChars), 1'b0);
    pace_sender();

    target = text_items + 80;
    while (text_items < target) send_token();

    target = text_items + 60;
    while (text_items < target) send_token();

    close_text();
    drain_results();
    repeat (DrainCycles) @(posedge clk);

    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
